[rtl/fupe_pkg.sv]
`default_nettype none

package fupe_pkg;

  localparam int unsigned NumSlots = 8;
  localparam int unsigned SlotIdxW = $clog2(NumSlots);
  localparam int unsigned SlotCntW = $clog2(NumSlots + 1);
  localparam int unsigned PrefixLen = 7;

  localparam logic [15:0] CapReset = 16'd12304;
  localparam logic [7:0]  ChSlash = 8'h2f;
  localparam logic [7:0]  ChPercent = 8'h25;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PATH = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_OUT_CAPACITY = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    status_e    st;
  } result_t;

  typedef struct packed {
    result_t [NumSlots-1:0] ent;
    logic [SlotCntW-1:0]    cnt;
  } burst_t;

  function automatic logic passes_through(input logic [7:0] b);
    logic ok;
    ok = ((b >= 8'h41) && (b <= 8'h5a)) || ((b >= 8'h61) && (b <= 8'h7a)) ||
         ((b >= 8'h30) && (b <= 8'h39)) || (b == 8'h2d) || (b == 8'h5f) ||
         (b == 8'h2e) || (b == 8'h7e) || (b == ChSlash);
    return ok;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h37 + {4'h0, nib};
    end
    return c;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h66;
      3'd1:    c = 8'h69;
      3'd2:    c = 8'h6c;
      3'd3:    c = 8'h65;
      3'd4:    c = 8'h3a;
      3'd5:    c = 8'h2f;
      3'd6:    c = 8'h2f;
      default: c = ChSlash;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/fupe_cfg.sv]
`default_nettype none

module fupe_cfg
  import fupe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [15:0]      cap_o
);

  logic [15:0] cap_q;
  logic [15:0] cap_d;
  logic        hit;

  assign pready = 1'b1;
  assign hit = (paddr[2] == REG_OUT_CAPACITY) && (paddr[1:0] == 2'b00);

  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && pready && hit) begin
      cap_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign prdata = hit ? {16'h0000, cap_q} : 32'h0000_0000;
  assign cap_o = cap_q;

endmodule

`default_nettype wire

[rtl/fupe_expand.sv]
`default_nettype none

module fupe_expand
  import fupe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] path_byte_i,
  input  wire logic       end_of_path_i,
  input  wire logic [15:0] cap_i,
  output burst_t          burst_o
);

  logic [15:0] wc_q, wc_d;
  logic        started_q, started_d;
  logic        failed_q, failed_d;

  logic [17:0]         avail;
  logic [3:0]          space;
  logic [SlotCntW-1:0] nchars;
  logic                marker;
  status_e             mst;
  logic [7:0]          chars [NumSlots];

  always_comb begin
    avail = {2'b00, cap_i} - {2'b00, wc_q} - 18'd1;
    if (avail[17]) begin
      space = 4'd0;
    end else if (avail[16:0] > 17'd15) begin
      space = 4'd15;
    end else begin
      space = avail[3:0];
    end

    nchars = '0;
    marker = 1'b0;
    mst = ST_OK;
    wc_d = wc_q;
    started_d = started_q;
    failed_d = failed_q;
    for (int i = 0; i < NumSlots; i++) begin
      chars[i] = 8'h00;
    end

    if (accept_i) begin
      if (end_of_path_i) begin
        if (!failed_q) begin
          marker = 1'b1;
          if (!started_q) begin
            mst = ST_BAD_PATH;
          end else if (space == 4'd0) begin
            mst = ST_OVERFLOW;
          end else begin
            mst = ST_OK;
          end
        end
        wc_d = '0;
        started_d = 1'b0;
        failed_d = 1'b0;
      end else if (failed_q) begin
        wc_d = wc_q;
      end else if (!started_q) begin
        if (path_byte_i != ChSlash) begin
          marker = 1'b1;
          mst = ST_BAD_PATH;
          failed_d = 1'b1;
        end else begin
          started_d = 1'b1;
          for (int i = 0; i < NumSlots; i++) begin
            chars[i] = (i < PrefixLen) ? prefix_char(3'(i)) : ChSlash;
          end
          if (space < 4'(NumSlots)) begin
            nchars = SlotCntW'(space);
            marker = 1'b1;
            mst = ST_OVERFLOW;
            failed_d = 1'b1;
          end else begin
            nchars = SlotCntW'(NumSlots);
            wc_d = wc_q + 16'(NumSlots);
          end
        end
      end else if (passes_through(path_byte_i)) begin
        chars[0] = path_byte_i;
        if (space == 4'd0) begin
          marker = 1'b1;
          mst = ST_OVERFLOW;
          failed_d = 1'b1;
        end else begin
          nchars = SlotCntW'(1);
          wc_d = wc_q + 16'd1;
        end
      end else begin
        chars[0] = ChPercent;
        chars[1] = hex_char(path_byte_i[7:4]);
        chars[2] = hex_char(path_byte_i[3:0]);
        if (space < 4'd3) begin
          marker = 1'b1;
          mst = ST_OVERFLOW;
          failed_d = 1'b1;
        end else begin
          nchars = SlotCntW'(3);
          wc_d = wc_q + 16'd3;
        end
      end
    end

    for (int i = 0; i < NumSlots; i++) begin
      if (SlotCntW'(i) < nchars) begin
        burst_o.ent[i] = '{ch: chars[i], last: 1'b0, st: ST_OK};
      end else if ((SlotCntW'(i) == nchars) && marker) begin
        burst_o.ent[i] = '{ch: 8'h00, last: 1'b1, st: mst};
      end else begin
        burst_o.ent[i] = '{ch: 8'h00, last: 1'b0, st: ST_OK};
      end
    end
    burst_o.cnt = nchars + SlotCntW'(marker);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q <= '0;
      started_q <= 1'b0;
      failed_q <= 1'b0;
    end else begin
      wc_q <= wc_d;
      started_q <= started_d;
      failed_q <= failed_d;
    end
  end

endmodule

`default_nettype wire

[rtl/fupe_drain.sv]
`default_nettype none

module fupe_drain
  import fupe_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   load_i,
  input  wire burst_t burst_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        last_out_o,
  output logic [1:0]  status_o
);

  result_t [NumSlots-1:0] ent_q, ent_d;
  logic [SlotCntW-1:0]    cnt_q, cnt_d;
  logic [SlotIdxW-1:0]    idx_q, idx_d;
  logic                   vld_q, vld_d;
  logic                   take;
  logic                   final_take;
  result_t                cur;

  assign take = vld_q && out_ready_i;
  assign final_take = take && ((SlotCntW'(idx_q) + SlotCntW'(1)) == cnt_q);
  assign in_ready_o = !vld_q || final_take;

  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    vld_d = vld_q;
    if (load_i) begin
      ent_d = burst_i.ent;
      cnt_d = burst_i.cnt;
      idx_d = '0;
      vld_d = (burst_i.cnt != '0);
    end else if (final_take) begin
      vld_d = 1'b0;
    end else if (take) begin
      idx_d = idx_q + SlotIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign cur = ent_q[idx_q];
  assign out_valid_o = vld_q;
  assign out_char_o = cur.ch;
  assign last_out_o = cur.last;
  assign status_o = cur.st;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (SlotCntW'(idx_q) < cnt_q))
    else $error("slot index past request count");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !out_ready_i) |=> (vld_q && $stable(idx_q)))
    else $error("burst advanced without a taker");

  a_load_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (idx_q == '0))
    else $error("new request did not restart slot index");

endmodule

`default_nettype wire

[rtl/file_uri_percent_encoder.sv]
`default_nettype none

// The first result, if any, appears in the cycle after the request is accepted.
// Each request gives 0 to 8 results, one per cycle while out_ready_i is high; a
// byte gives 1 or 3, the first byte of a path up to 8. The next request is
// taken in the cycle the last result of the previous one is taken, so the rate
// is set by the result port. Reset clears path state and sets capacity to 12304.

module file_uri_percent_encoder
  import fupe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  path_byte_i,
  input  wire logic        end_of_path_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_char_o,
  output logic             last_out_o,
  output logic [1:0]       status_o
);

  logic [15:0] cap;
  logic        accept;
  burst_t      burst;

  assign accept = in_valid_i && in_ready_o;

  fupe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  fupe_expand u_expand (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .path_byte_i   (path_byte_i),
    .end_of_path_i (end_of_path_i),
    .cap_i         (cap),
    .burst_o       (burst)
  );

  fupe_drain u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .burst_i     (burst),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_out_o  (last_out_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

[bench/file_uri_percent_encoder_tb.sv]
module file_uri_percent_encoder_tb;
  import fupe_pkg::*;

  localparam logic [2:0] CapAddr = {REG_OUT_CAPACITY, 2'b00};
  localparam logic [2:0] SpareAddr = 3'd4;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned SettleCycles = 16;

  typedef struct {
    logic [7:0] pb;
    logic       eop;
  } path_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  path_byte_i = '0;
  logic        end_of_path_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_char_o;
  logic        last_out_o;
  logic [1:0]  status_o;

  file_uri_percent_encoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .path_byte_i  (path_byte_i),
    .end_of_path_i(end_of_path_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .last_out_o   (last_out_o),
    .status_o     (status_o)
  );

  path_req_t   path_q[$];
  result_t     uri_exp_q[$];

  int unsigned tx_idle_pct = 17;
  int unsigned rx_idle_pct = 53;
  logic        hold_go = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_cnt = 0;

  int unsigned err_cnt = 0;
  int unsigned req_cnt = 0;
  int unsigned char_cnt_seen = 0;
  int unsigned n_ok = 0;
  int unsigned n_bad = 0;
  int unsigned n_ovf = 0;

  logic [15:0] cap_cfg = CapReset;
  logic [15:0] emitted;
  logic        started = 1'b0;
  logic        failed = 1'b0;

  string       safe_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_.~/";
  string       scheme = "file://";
  string       hex_set = "0123456789ABCDEF";

  initial begin
    emitted = '0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic is_safe(input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < safe_set.len(); i++) begin
      if (b == safe_set[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic has_room(input int unsigned k);
    return (int'(emitted) + int'(k)) < int'(cap_cfg);
  endfunction

  function automatic void expect_char(input logic [7:0] c, input logic l, input status_e s);
    result_t r;
    r.ch = c;
    r.last = l;
    r.st = s;
    uri_exp_q.push_back(r);
    if (l) begin
      case (s)
        ST_OK:       n_ok++;
        ST_BAD_PATH: n_bad++;
        default:     n_ovf++;
      endcase
    end
  endfunction

  function automatic void emit(input logic [7:0] c);
    expect_char(c, 1'b0, ST_OK);
    emitted = emitted + 16'd1;
  endfunction

  function automatic void encode_request(input logic [7:0] pb, input logic eop);
    if (eop) begin
      if (!failed) begin
        if (!started) expect_char(8'h00, 1'b1, ST_BAD_PATH);
        else if (!has_room(1)) expect_char(8'h00, 1'b1, ST_OVERFLOW);
        else expect_char(8'h00, 1'b1, ST_OK);
      end
      emitted = '0;
      started = 1'b0;
      failed = 1'b0;
      return;
    end
    if (failed) return;
    if (!started) begin
      if (pb != ChSlash) begin
        expect_char(8'h00, 1'b1, ST_BAD_PATH);
        failed = 1'b1;
        return;
      end
      started = 1'b1;
      for (int i = 0; i < scheme.len(); i++) begin
        if (!has_room(1)) begin
          expect_char(8'h00, 1'b1, ST_OVERFLOW);
          failed = 1'b1;
          return;
        end
        emit(scheme[i]);
      end
    end
    if (is_safe(pb)) begin
      if (!has_room(1)) begin
        expect_char(8'h00, 1'b1, ST_OVERFLOW);
        failed = 1'b1;
        return;
      end
      emit(pb);
    end else begin
      if (!has_room(3)) begin
        expect_char(8'h00, 1'b1, ST_OVERFLOW);
        failed = 1'b1;
        return;
      end
      emit(ChPercent);
      emit(hex_set[pb[7:4]]);
      emit(hex_set[pb[3:0]]);
    end
  endfunction

  // driver: advance to the next pending request once the current one is taken
  always @(posedge clk_i) begin
    path_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        encode_request(path_byte_i, end_of_path_i);
        req_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (path_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          nxt = path_q.pop_front();
          in_valid_i <= 1'b1;
          path_byte_i <= nxt.pb;
          end_of_path_i <= nxt.eop;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt <= 0;
      hold_seen <= 1'b0;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_cnt <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      char_cnt_seen++;
      if (uri_exp_q.size() == 0) begin
        $display("%0t: unexpected result: ch=%02h last=%0d st=%0d", $time,
                 out_char_o, last_out_o, status_o);
        err_cnt++;
      end else begin
        e = uri_exp_q.pop_front();
        if (out_char_o !== e.ch || last_out_o !== e.last || status_o !== e.st) begin
          $display("%0t: mismatch: expected ch=%02h last=%0d st=%0d, got ch=%02h last=%0d st=%0d",
                   $time, e.ch, e.last, e.st, out_char_o, last_out_o, status_o);
          err_cnt++;
        end
      end
    end
  end

  task automatic push_req(input logic [7:0] pb, input logic eop);
    path_req_t r;
    r.pb = pb;
    r.eop = eop;
    path_q.push_back(r);
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (path_q.size() != 0 || in_valid_i || uri_exp_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == CapAddr) cap_cfg = data[15:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_read_check(input logic [2:0] addr, input logic [15:0] want);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata[15:0] !== want) begin
      $display("%0t: mismatch: expected capacity=%0d, got %0d", $time, want, prdata[15:0]);
      err_cnt++;
    end
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] path_char();
    if ($urandom_range(0, 99) < 65) return safe_set[$urandom_range(0, safe_set.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly well-formed paths, with empty and relative ones mixed in
  task automatic random_paths(input int unsigned n_items);
    int unsigned added;
    int unsigned kind;
    int unsigned len;
    logic [7:0] first;
    added = 0;
    while (added < n_items) begin
      kind = $urandom_range(0, 9);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
      if (kind == 0) begin
        push_req(8'($urandom_range(0, 255)), 1'b1);
        added += 1;
      end else begin
        if (kind == 1) begin
          do first = 8'($urandom_range(0, 255)); while (first == ChSlash);
        end else begin
          first = ChSlash;
        end
        push_req(first, 1'b0);
        for (int i = 0; i < len; i++) push_req(path_char(), 1'b0);
        push_req(8'($urandom_range(0, 255)), 1'b1);
        added += len + 2;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    cfg_read_check(CapAddr, CapReset);

    push_req(8'h00, 1'b1);
    push_req("a", 1'b0);
    push_req(ChSlash, 1'b0);
    push_req(8'hff, 1'b1);
    push_req(ChSlash, 1'b0);
    push_req("A", 1'b0);
    push_req("Z", 1'b0);
    push_req("a", 1'b0);
    push_req("z", 1'b0);
    push_req("0", 1'b0);
    push_req("9", 1'b0);
    push_req("-", 1'b0);
    push_req("_", 1'b0);
    push_req(".", 1'b0);
    push_req("~", 1'b0);
    push_req(8'h00, 1'b0);
    push_req(8'hff, 1'b0);
    push_req(8'h20, 1'b0);
    push_req(8'h00, 1'b1);
    drain();

    // shrink the capacity in the middle of a path
    push_req(ChSlash, 1'b0);
    push_req("a", 1'b0);
    push_req("b", 1'b0);
    drain();
    cfg_write(CapAddr, 32'd12);
    push_req("c", 1'b0);
    push_req(8'h00, 1'b1);
    drain();

    cfg_write(SpareAddr, 32'h0000_0001);
    cfg_read_check(CapAddr, 16'd12);

    cfg_write(CapAddr, 32'd0);
    random_paths(15);
    drain();
    cfg_write(CapAddr, 32'd4);
    random_paths(15);
    drain();
    cfg_write(CapAddr, 32'd11);
    random_paths(20);
    drain();

    cfg_write(CapAddr, 32'd65535);
    cfg_read_check(CapAddr, 16'd65535);
    random_paths(120);
    @(posedge clk_i);
    hold_go <= ~hold_go;
    drain();

    tx_idle_pct = 53;
    rx_idle_pct = 17;
    cfg_write(CapAddr, 32'($urandom_range(8, 48)));
    random_paths(120);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    cfg_write(CapAddr, 32'($urandom_range(30, 300)));
    random_paths(120);
    @(posedge clk_i);
    hold_go <= ~hold_go;
    drain();

    $display("Sent %0d requests and checked %0d characters; paths ended ok %0d, rejected %0d, overflowed %0d.",
             req_cnt, char_cnt_seen, n_ok, n_bad, n_ovf);
    $display("Capacities from 0 to 65535, a mid-path capacity change and two long output hold-offs.");
    if (err_cnt == 0 && uri_exp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[file_uri_percent_encoder.f]
rtl/fupe_pkg.sv
rtl/fupe_cfg.sv
rtl/fupe_expand.sv
rtl/fupe_drain.sv
rtl/file_uri_percent_encoder.sv
bench/file_uri_percent_encoder_tb.sv
